@@ rtl/spin_block_average_downsample_top_defines.svh @@
// Assertion macros used by the block's checker.
`ifndef SPIN_BLOCK_AVERAGE_DOWNSAMPLE_TOP_DEFINES_SVH
`define SPIN_BLOCK_AVERAGE_DOWNSAMPLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SBAD_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("sbad check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SBAD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("sbad check failed");

`endif

@@ rtl/sbad_pkg.sv @@
// Shared constants, types and the contrast table of the block-average downsampler.
`timescale 1ns / 1ps
package sbad_pkg;

  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_BLOCK     = 64;
  localparam int LATTICE_SHIFT = 17;   // lattice row pitch is 2^17 sites

  localparam int COL_W    = $clog2(MAX_OUT_WIDTH);  // pixel column / band index
  localparam int BLK_W    = $clog2(MAX_BLOCK);      // position inside a block
  localparam int BL_W     = 7;                      // block side register
  localparam int OW_W     = 11;                     // out_width register
  localparam int RECIP_W  = 24;
  localparam int ORIGIN_W = 17;
  localparam int SUM_W    = 13;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int FRAC_SH  = 16;
  localparam int GRAY_W   = 8;
  localparam int POS_W    = ORIGIN_W + 1;
  localparam int CORNER_FULL_W = POS_W + LATTICE_SHIFT;
  localparam int CORNER_W = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - GRAY_W - 2 * COL_W - CORNER_W;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

  localparam logic [BL_W-1:0]    RESET_BLOCK_SIDE = 7'd1;
  localparam logic [OW_W-1:0]    RESET_OUT_WIDTH  = 11'd1;
  localparam logic [RECIP_W-1:0] RESET_RECIP      = 24'd16711680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIDE   = 3'd0,
    REG_OUT_WIDTH    = 3'd1,
    REG_RECIP_SCALE  = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BL_W-1:0]     bl;        // effective block side, 1..MAX_BLOCK
    logic [RECIP_W-1:0]  recip;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic             spin;
    logic             first;       // first site of a block: sum restarts
    logic             last;        // last site of a block: pixel is due
    logic [COL_W-1:0] ci;
    logic [COL_W-1:0] band;
    logic             frame_last;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [COL_W-1:0] ci;
    logic [COL_W-1:0] band;
    logic             frame_last;
  } sum_item_t;

  typedef struct packed {
    logic [GRAY_W-1:0]   gray;
    logic [COL_W-1:0]    pix_x;
    logic [COL_W-1:0]    pix_y;
    logic [CORNER_W-1:0] block_corner;
    logic                frame_last;
  } pixel_t;

  // Contrast table, built at elaboration with exact integer arithmetic.
  localparam int EXP_W = 80;
  localparam int DIV_W = 16;
  localparam int WIDE_W = 128;

  typedef logic [255:0][GRAY_W-1:0] rom_t;

  // Shift-subtract quotient for table construction.
  function automatic logic [EXP_W-1:0] div_small(input logic [EXP_W-1:0] num,
                                                 input logic [DIV_W-1:0] den);
    logic [EXP_W-1:0] quo;
    logic [DIV_W:0]   rem;
    quo = '0;
    rem = '0;
    for (int b = EXP_W - 1; b >= 0; b--) begin
      rem = {rem[DIV_W-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(m/85) in Q54 by a truncated series of 101 terms.
  function automatic logic [EXP_W-1:0] exp_q54(input logic [9:0] m);
    logic [EXP_W-1:0] term;
    logic [EXP_W-1:0] acc;
    term = EXP_W'(1) << 54;
    acc  = term;
    for (int n = 1; n <= 100; n++) begin
      term = div_small(term * {{(EXP_W-10){1'b0}}, m}, DIV_W'(85 * n));
      acc  = acc + term;
    end
    return acc;
  endfunction

  // Upper half from the tanh expression in exponential form, lower half by symmetry.
  function automatic rom_t build_contrast_rom();
    rom_t               rom;
    logic [WIDE_W-1:0]  e6;
    logic [WIDE_W-1:0]  u;
    logic [WIDE_W-1:0]  num;
    logic [WIDE_W-1:0]  den;
    logic [WIDE_W-1:0]  q40;
    logic [GRAY_W-1:0]  k;
    logic               done;
    rom = '0;
    q40 = WIDE_W'(1) << 40;
    e6  = {{(WIDE_W-EXP_W){1'b0}}, exp_q54(10'd510)} >> 14;
    for (int i = 128; i < 256; i++) begin
      u = {{(WIDE_W-EXP_W){1'b0}}, exp_q54(10'(2 * (2 * i - 255)))} >> 14;
      if (u > e6) u = e6;
      num  = WIDE_W'(510) * (e6 - u) * q40;
      k    = '0;
      done = 1'b0;
      for (int j = 0; j < 255; j++) begin
        if (!done) begin
          den = WIDE_W'(2 * j + 1) * (u + q40) * (e6 - q40);
          if (den > num) done = 1'b1;
          else k = k + 8'd1;
        end
      end
      rom[8'(i)]       = k;
      rom[8'(255 - i)] = 8'd255 - k;
    end
    return rom;
  endfunction

  localparam rom_t CONTRAST_ROM = build_contrast_rom();

endpackage

@@ rtl/sbad_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sbad_ctrl.sv @@
// Configuration registers and raster position counters; registers each accepted bit.
`timescale 1ns / 1ps
module sbad_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [sbad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  input  logic                            raw_bit,
  output sbad_pkg::cfg_t                  cfg,
  output logic [sbad_pkg::COL_W-1:0]      rd_addr,
  output logic                            item_valid,
  output sbad_pkg::item_t                 item
);
  import sbad_pkg::*;

  logic [BL_W-1:0]     block_side;
  logic [OW_W-1:0]     out_width;
  logic [RECIP_W-1:0]  recip_scale;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;

  logic [BLK_W-1:0] kb;
  logic [COL_W-1:0] ci;
  logic [BLK_W-1:0] row;
  logic [COL_W-1:0] band;
  logic [BLK_W-1:0] kb_next;
  logic [COL_W-1:0] ci_next;
  logic [BLK_W-1:0] row_next;
  logic [COL_W-1:0] band_next;

  logic [BL_W-1:0]  bl_eff;
  logic [OW_W-1:0]  ow_eff;
  logic [BLK_W-1:0] bl_m1;
  logic [COL_W-1:0] ow_m1;
  logic             restart;
  item_t            item_next;

  always_comb begin
    if (block_side == '0) begin
      bl_eff = BL_W'(1);
    end else if (block_side > BL_W'(MAX_BLOCK)) begin
      bl_eff = BL_W'(MAX_BLOCK);
    end else begin
      bl_eff = block_side;
    end
    if (out_width == '0) begin
      ow_eff = OW_W'(1);
    end else if (out_width > OW_W'(MAX_OUT_WIDTH)) begin
      ow_eff = OW_W'(MAX_OUT_WIDTH);
    end else begin
      ow_eff = out_width;
    end
  end

  assign bl_m1 = BLK_W'(bl_eff - BL_W'(1));
  assign ow_m1 = COL_W'(ow_eff - OW_W'(1));

  assign cfg.bl       = bl_eff;
  assign cfg.recip    = recip_scale;
  assign cfg.origin_x = origin_x;
  assign cfg.origin_y = origin_y;

  // A new block size or image size starts a fresh frame.
  assign restart = cfg_valid && (cfg_index == REG_BLOCK_SIDE || cfg_index == REG_OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_side   <= RESET_BLOCK_SIDE;
      out_width    <= RESET_OUT_WIDTH;
      recip_scale  <= RESET_RECIP;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIDE:   block_side   <= cfg_data[BL_W-1:0];
        REG_OUT_WIDTH:    out_width    <= cfg_data[OW_W-1:0];
        REG_RECIP_SCALE:  recip_scale  <= cfg_data[RECIP_W-1:0];
        REG_ORIGIN_X:     origin_x     <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kb_next   = kb + BLK_W'(1);
    ci_next   = ci;
    row_next  = row;
    band_next = band;
    if (kb == bl_m1) begin
      kb_next = '0;
      if (ci == ow_m1) begin
        ci_next = '0;
        if (row == bl_m1) begin
          row_next  = '0;
          band_next = (band == ow_m1) ? '0 : band + COL_W'(1);
        end else begin
          row_next = row + BLK_W'(1);
        end
      end else begin
        ci_next = ci + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      kb   <= '0;
      ci   <= '0;
      row  <= '0;
      band <= '0;
    end else if (accept) begin
      kb   <= kb_next;
      ci   <= ci_next;
      row  <= row_next;
      band <= band_next;
    end
  end

  always_comb begin
    item_next.spin       = ~raw_bit;
    item_next.first      = (row == '0) && (kb == '0);
    item_next.last       = (row == bl_m1) && (kb == bl_m1);
    item_next.ci         = ci;
    item_next.band       = band;
    item_next.frame_last = (ci == ow_m1) && (band == ow_m1);
  end

  assign rd_addr = ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/sbad_colsum.sv @@
// Per-column spin accumulators: RAM read-modify-write with write forwarding.
`timescale 1ns / 1ps
module sbad_colsum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [sbad_pkg::COL_W-1:0] rd_addr,
  input  logic                       item_valid,
  input  sbad_pkg::item_t            item,
  output logic                       sum_valid,
  output sbad_pkg::sum_item_t        sum_item
);
  import sbad_pkg::*;

  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W-1:0] sum_next;
  logic             fwd_valid;
  logic [COL_W-1:0] fwd_addr;
  logic [SUM_W-1:0] fwd_data;

  sbad_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (item_valid),
    .wr_addr (item.ci),
    .wr_data (sum_next),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The most recent write may land on the same edge as the read; take it from here.
  assign old_sum  = (fwd_valid && fwd_addr == item.ci) ? fwd_data : rd_data;
  assign sum_next = item.first ? {{(SUM_W-1){1'b0}}, item.spin}
                               : old_sum + {{(SUM_W-1){1'b0}}, item.spin};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      fwd_valid <= fwd_valid | item_valid;
      sum_valid <= item_valid && item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      fwd_addr            <= item.ci;
      fwd_data            <= sum_next;
      sum_item.sum        <= sum_next;
      sum_item.ci         <= item.ci;
      sum_item.band       <= item.band;
      sum_item.frame_last <= item.frame_last;
    end
  end

endmodule

@@ rtl/sbad_pixel.sv @@
// Pixel finish: fraction multiply, corner address, saturation and contrast lookup.
`timescale 1ns / 1ps
module sbad_pixel (
  input  logic                clk,
  input  logic                rst,
  input  sbad_pkg::cfg_t      cfg,
  input  logic                sum_valid,
  input  sbad_pkg::sum_item_t sum_item,
  output logic                pix_valid,
  output sbad_pkg::pixel_t    pix
);
  import sbad_pkg::*;

  logic [PROD_W-1:0]        prod;
  logic [POS_W-1:0]         col_pos;
  logic [POS_W-1:0]         row_pos;
  logic [COL_W-1:0]         pix_x;
  logic [COL_W-1:0]         pix_y;
  logic                     frame_last;
  logic [GRAY_W-1:0]        frac;
  logic [CORNER_FULL_W-1:0] corner_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      prod       <= PROD_W'(sum_item.sum) * PROD_W'(cfg.recip);
      col_pos    <= POS_W'(cfg.origin_x) + POS_W'(sum_item.ci) * POS_W'(cfg.bl);
      row_pos    <= POS_W'(cfg.origin_y) + POS_W'(sum_item.band) * POS_W'(cfg.bl);
      pix_x      <= sum_item.ci;
      pix_y      <= sum_item.band;
      frame_last <= sum_item.frame_last;
    end
  end

  // Saturate the scaled fraction at full scale.
  assign frac = (prod[PROD_W-1:FRAC_SH+GRAY_W] != '0) ? '1 : prod[FRAC_SH+GRAY_W-1:FRAC_SH];

  assign corner_full = {row_pos, {LATTICE_SHIFT{1'b0}}}
                     + {{(CORNER_FULL_W-POS_W){1'b0}}, col_pos};

  assign pix.gray         = CONTRAST_ROM[frac];
  assign pix.pix_x        = pix_x;
  assign pix.pix_y        = pix_y;
  assign pix.block_corner = corner_full[CORNER_W-1:0];
  assign pix.frame_last   = frame_last;

endmodule

@@ rtl/sbad_outq.sv @@
// Result queue between the pixel pipeline and the output stream.
`timescale 1ns / 1ps
module sbad_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  sbad_pkg::pixel_t                push_data,
  input  logic                            pop,
  output logic                            not_empty,
  output sbad_pkg::pixel_t                head,
  output logic [sbad_pkg::OUTQ_CNT_W-1:0] count
);
  import sbad_pkg::*;

  pixel_t              entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic                  do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - OUTQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/spin_block_average_downsample_top.sv @@
// Top level of the spin block-average downsampler with tanh contrast map.
//
// Input stream s_axis_*: one lattice bit per transfer (tdata bit 0), raster order
// over a square window of out_width times the block side sites a side. Each raw 0
// counts as an up spin. Output stream m_axis_*: one gray pixel per completed block,
// in raster order, with its coordinates and the lattice index of the block corner;
// tlast marks the last pixel of a frame.
// Config channel cfg_*: register index and data, always ready; write only while
// the block is idle. Writing the block side or out_width restarts the frame.
// Throughput: one bit per clock while s_axis_tready is high. A pixel reaches m_axis
// after the transfer of its block's last bit through column-sum RAM read, sum update and
// write, fraction multiply, then saturation and table lookup into the queue.
// The eight-entry result queue absorbs receiver stalls; s_axis_tready drops only
// when queued plus in-flight pixels would fill it.
// Reset clears the counters, the queue and the in-flight flags and loads the
// register defaults. Column sums need no clear: a block's first bit overwrites.
`timescale 1ns / 1ps
module spin_block_average_downsample_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sbad_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [0] raw_bit
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sbad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // gray, pix_x, pix_y, block_corner
  output logic                             m_axis_tlast,   // frame_last
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbad_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbad_pkg::*;

  cfg_t                  cfg;
  logic                  accept;
  logic [COL_W-1:0]      rd_addr;
  logic                  item_valid;
  item_t                 item;
  logic                  sum_valid;
  sum_item_t             sum_item;
  logic                  pix_valid;
  pixel_t                pix;
  pixel_t                head;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   pending;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Reserve queue room for every pixel still in the pipeline.
  assign pending = (OUTQ_CNT_W+1)'(q_count)
                 + (OUTQ_CNT_W+1)'(item_valid && item.last)
                 + (OUTQ_CNT_W+1)'(sum_valid)
                 + (OUTQ_CNT_W+1)'(pix_valid);
  assign s_axis_tready = (pending < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

  sbad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .raw_bit    (s_axis_tdata[0]),
    .cfg        (cfg),
    .rd_addr    (rd_addr),
    .item_valid (item_valid),
    .item       (item)
  );

  sbad_colsum u_colsum (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_addr    (rd_addr),
    .item_valid (item_valid),
    .item       (item),
    .sum_valid  (sum_valid),
    .sum_item   (sum_item)
  );

  sbad_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_item  (sum_item),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  sbad_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (pix_valid),
    .push_data (pix),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .count     (q_count)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, head.block_corner, head.pix_y, head.pix_x, head.gray};
  assign m_axis_tlast = head.frame_last;

endmodule

@@ rtl/sbad_checker.sv @@
// Port-level checks of the downsampler, bound to the top level.
`timescale 1ns / 1ps
`include "spin_block_average_downsample_top_defines.svh"
module sbad_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbad_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // A stalled result holds.
  `SBAD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Reset empties the queue and the pipeline, so input is taken right away.
  `SBAD_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready)

  // The frame's last pixel is the bottom-right corner of a square image.
  `SBAD_ASSERT_IMPLY(a_last_diag, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[17:8] == m_axis_tdata[27:18])

  // Padding above block_corner stays zero.
  `SBAD_ASSERT_IMPLY(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[63:62] == 2'b00)

endmodule

bind spin_block_average_downsample_top sbad_checker u_sbad_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
